// File: rtl/filtered_stereo_correlation_defines.svh
// Assertion macros for the stereo correlation block
`ifndef FILTERED_STEREO_CORRELATION_DEFINES_SVH
`define FILTERED_STEREO_CORRELATION_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FSC_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FSC_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FSC_ASSERT_IMPL(label, clk, rst, prop, msg)
`define FSC_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// File: rtl/fsc_pkg.sv
package fsc_pkg;
   localparam int SampleBitsDef = 16;
   localparam int FilterBitsDef = 24;
   localparam int CoefBits      = 16;
   localparam logic [CoefBits-1:0] CoefReset = 16'd4780;
   localparam int AccBits       = 64;
   localparam int CorrBits      = 16;
   localparam logic [CorrBits-1:0] CorrMax = 16'h7FFF;
endpackage

// File: rtl/fsc_if.sv
// Valid/ready channel carrying one word of type payload_type
interface fsc_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/filtered_stereo_correlation.sv
// Stereo correlation meter, bit-serial datapath.
// Per pair, one shared serial multiplier computes two filter taps per channel
// and three products. Block end adds two square roots, one serial 32x32 product,
// and a 64-step restoring divide.
// Synchronous active-high reset: coefficient to 4780, filters, sums and flag to zero.
`include "filtered_stereo_correlation_defines.svh"
module filtered_stereo_correlation #(
   parameter int SAMPLE_BITS = fsc_pkg::SampleBitsDef,
   parameter int FILTER_BITS = fsc_pkg::FilterBitsDef
) (
   input logic clock,
   input logic reset,
   fsc_if.sink   req,
   fsc_if.source rsp,
   fsc_if.sink   csr
);
   import fsc_pkg::*;
   localparam int MW = 34;   // multiplier operand width (filter bits, coef+sign or root+sign)
   localparam int WB = (FILTER_BITS > 18 ? FILTER_BITS : 18) + 2;

   typedef enum logic [3:0] {
      S_IDLE, S_FILT1, S_FILT2, S_PROD, S_ACC, S_NORM, S_SQRT, S_DMUL, S_DIV, S_OUT
   } state_type;

   state_type state_ff;
   logic [CoefBits-1:0] coef_ff;
   logic signed [FILTER_BITS-1:0] yl_ff, yr_ff;
   logic signed [AccBits-1:0] cross_ff, el_ff, er_ff;
   logic sat_ff, last_ff, ch_ff, tap_ff;
   logic [1:0] pidx_ff;
   logic signed [FILTER_BITS-1:0] xs_ff;
   logic signed [WB+18-1:0] facc_ff;
   logic signed [2*MW-1:0] prod_hold_ff;
   // normalization/sqrt/divide
   logic [AccBits-1:0] nv_ff, rem_ff, res_ff, one_ff;
   logic signed [7:0] h_ff, hsum_ff;
   logic nch_ff;
   logic [31:0] sl_ff, sr_ff;
   logic [AccBits-1:0] d_ff, mag_ff, q_ff, r_ff;
   logic [6:0] dcnt_ff;
   logic neg_ff;
   logic signed [7:0] t_ff;
   logic rsp_valid_ff;
   logic [CorrBits-1:0] corr_ff;
   logic silent_ff, ovf_ff;

   // shared multiplier
   logic mstart;
   logic signed [MW-1:0] ma, mb;
   logic mdone;
   logic signed [2*MW-1:0] mprod;
   fsc_serial_mac #(.WIDTH(MW)) u_mac (
      .clock(clock), .reset(reset), .start(mstart), .a(ma), .b(mb),
      .done(mdone), .product(mprod));

   logic mbusy_ff;
   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr.ready = 1'b1;

   // sample widened to filter scale
   function automatic logic signed [FILTER_BITS-1:0] widen(input logic signed [SAMPLE_BITS-1:0] x);
      if (FILTER_BITS >= SAMPLE_BITS) widen = FILTER_BITS'($signed(x) <<< (FILTER_BITS - SAMPLE_BITS));
      else widen = FILTER_BITS'($signed(x) >>> (SAMPLE_BITS - FILTER_BITS));
   endfunction

   function automatic logic signed [AccBits-1:0] sat_add(input logic signed [AccBits-1:0] a,
                                                         input logic signed [AccBits-1:0] p,
                                                         output logic ov);
      logic signed [AccBits:0] s;
      s = {a[AccBits-1], a} + {p[AccBits-1], p};
      ov = s[AccBits] != s[AccBits-1];
      if (ov) sat_add = s[AccBits] ? {1'b1, {(AccBits-1){1'b0}}} : {1'b0, {(AccBits-1){1'b1}}};
      else sat_add = s[AccBits-1:0];
   endfunction

   // multiplier operand selection
   logic signed [FILTER_BITS-1:0] ycur;
   assign ycur = ch_ff ? yr_ff : yl_ff;
   always_comb begin
      ma = '0; mb = '0;
      if (state_ff == S_FILT1) begin
         ma = MW'(xs_ff);
         mb = MW'($signed({1'b0, 17'(18'h10000 - {2'b0, coef_ff})}));
      end else if (state_ff == S_FILT2) begin
         ma = MW'(ycur);
         mb = MW'($signed({1'b0, coef_ff}));
      end else if (state_ff == S_PROD) begin
         ma = (pidx_ff == 2'd2) ? MW'(yr_ff) : MW'(yl_ff);
         mb = (pidx_ff == 2'd1) ? MW'(yl_ff) : MW'(yr_ff);
      end else if (state_ff == S_DMUL) begin
         ma = MW'($signed({1'b0, sl_ff}));
         mb = MW'($signed({1'b0, sr_ff}));
      end
   end
   assign mstart = !mbusy_ff && (state_ff == S_FILT1 || state_ff == S_FILT2 ||
                   state_ff == S_PROD || state_ff == S_DMUL) && !tap_ff;

   logic signed [WB+18-1:0] fsum, fsh;
   logic signed [FILTER_BITS-1:0] fclamp;
   localparam logic signed [WB+18-1:0] FHi = (WB+18)'((64'sd1 <<< (FILTER_BITS-1)) - 1);
   localparam logic signed [WB+18-1:0] FLo = -FHi - 1;
   always_comb begin
      fsum = facc_ff + (WB+18)'(mprod) + (WB+18)'(32768);
      fsh = fsum >>> 16;
      if (fsh > FHi) fclamp = FILTER_BITS'(FHi);
      else if (fsh < FLo) fclamp = FILTER_BITS'(FLo);
      else fclamp = FILTER_BITS'(fsh);
   end

   // isqrt step
   logic [AccBits-1:0] rone;
   assign rone = res_ff + one_ff;

   logic ov0;
   logic signed [AccBits-1:0] sadd;
   logic signed [AccBits-1:0] addend, accsel;
   always_comb begin
      accsel = (pidx_ff == 2'd0) ? cross_ff : (pidx_ff == 2'd1) ? el_ff : er_ff;
      addend = AccBits'(prod_hold_ff);
      sadd = sat_add(accsel, addend, ov0);
   end

   logic [AccBits-1:0] r2;
   assign r2 = {r_ff[AccBits-2:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; coef_ff <= CoefReset; yl_ff <= '0; yr_ff <= '0;
         cross_ff <= '0; el_ff <= '0; er_ff <= '0; sat_ff <= 1'b0;
         rsp_valid_ff <= 1'b0; mbusy_ff <= 1'b0; tap_ff <= 1'b0;
         ch_ff <= 1'b0; pidx_ff <= '0; last_ff <= 1'b0;
      end else begin
         if (csr.valid && csr.ready) coef_ff <= csr.payload;
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         if (mstart) mbusy_ff <= 1'b1;
         if (mdone) mbusy_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req.valid && req.ready) begin
               last_ff <= req.payload.last_sample;
               ch_ff <= 1'b0;
               xs_ff <= widen(req.payload.left_sample);
               sl_ff <= 32'(widen(req.payload.right_sample));  // park right sample
               state_ff <= S_FILT1;
            end
            S_FILT1: if (mdone) begin
               facc_ff <= (WB+18)'(mprod);
               state_ff <= S_FILT2;
            end
            S_FILT2: if (mdone) begin
               if (!ch_ff) begin
                  yl_ff <= fclamp;
                  xs_ff <= FILTER_BITS'(sl_ff);
                  ch_ff <= 1'b1;
                  state_ff <= S_FILT1;
               end else begin
                  yr_ff <= fclamp;
                  pidx_ff <= 2'd0;
                  state_ff <= S_PROD;
               end
            end
            S_PROD: if (mdone) begin
               prod_hold_ff <= mprod;
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (ov0) sat_ff <= 1'b1;
               case (pidx_ff)
                  2'd0: cross_ff <= sadd;
                  2'd1: el_ff <= sadd;
                  default: er_ff <= sadd;
               endcase
               if (pidx_ff != 2'd2) begin
                  pidx_ff <= pidx_ff + 2'd1;
                  state_ff <= S_PROD;
               end else if (!last_ff) begin
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_NORM;
                  nch_ff <= 1'b0;
                  hsum_ff <= '0;
                  h_ff <= '0;
                  nv_ff <= el_ff;
               end
            end
            S_NORM: begin
               // silent check before anything else
               if (el_ff == '0 || er_ff == '0) begin
                  corr_ff <= '0; silent_ff <= 1'b1; ovf_ff <= sat_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_OUT;
               end else if (nv_ff < (64'd1 << 60)) begin
                  nv_ff <= nv_ff << 2; h_ff <= h_ff - 8'sd1;
               end else if (nv_ff >= (64'd1 << 62)) begin
                  nv_ff <= nv_ff >> 2; h_ff <= h_ff + 8'sd1;
               end else begin
                  rem_ff <= nv_ff; res_ff <= '0; one_ff <= 64'd1 << 60;
                  hsum_ff <= hsum_ff + h_ff;
                  state_ff <= S_SQRT;
               end
            end
            S_SQRT: begin
               if (nv_ff >= rone) begin
                  nv_ff <= nv_ff - rone;
                  res_ff <= (res_ff >> 1) + one_ff;
               end else res_ff <= res_ff >> 1;
               one_ff <= one_ff >> 2;
               if (one_ff == 64'd1) begin
                  if (!nch_ff) begin
                     sl_ff <= 32'(nv_ff >= rone ? (res_ff >> 1) + one_ff : res_ff >> 1);
                     nch_ff <= 1'b1; nv_ff <= er_ff; h_ff <= '0;
                     state_ff <= S_NORM;
                  end else begin
                     sr_ff <= 32'(nv_ff >= rone ? (res_ff >> 1) + one_ff : res_ff >> 1);
                     state_ff <= S_DMUL;
                  end
               end
            end
            S_DMUL: if (mdone) begin
               d_ff <= AccBits'(mprod);
               neg_ff <= cross_ff[AccBits-1];
               mag_ff <= cross_ff[AccBits-1] ? AccBits'(-cross_ff) : AccBits'(cross_ff);
               t_ff <= 8'sd15 - hsum_ff;
               q_ff <= '0; r_ff <= '0; dcnt_ff <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               // restoring divide over 64 bits, then up to t_ff extra fraction bits
               if (dcnt_ff < 7'd64) begin
                  if ({r_ff[AccBits-2:0], mag_ff[AccBits-1]} >= d_ff || r_ff[AccBits-1]) begin
                     r_ff <= {r_ff[AccBits-2:0], mag_ff[AccBits-1]} - d_ff;
                     q_ff <= {q_ff[AccBits-2:0], 1'b1};
                  end else begin
                     r_ff <= {r_ff[AccBits-2:0], mag_ff[AccBits-1]};
                     q_ff <= {q_ff[AccBits-2:0], 1'b0};
                  end
                  mag_ff <= mag_ff << 1;
                  dcnt_ff <= dcnt_ff + 7'd1;
               end else if (t_ff > 8'sd0 && q_ff <= 64'd32767) begin
                  if (r2 >= d_ff || r_ff[AccBits-1]) begin
                     r_ff <= r2 - d_ff; q_ff <= {q_ff[AccBits-2:0], 1'b1};
                  end else begin
                     r_ff <= r2; q_ff <= {q_ff[AccBits-2:0], 1'b0};
                  end
                  t_ff <= t_ff - 8'sd1;
               end else begin
                  corr_ff <= (q_ff > 64'd32767) ? (neg_ff ? -CorrMax : CorrMax)
                             : (neg_ff ? -CorrBits'(q_ff) : CorrBits'(q_ff));
                  silent_ff <= 1'b0; ovf_ff <= sat_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               yl_ff <= '0; yr_ff <= '0; cross_ff <= '0; el_ff <= '0; er_ff <= '0;
               sat_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload.correlation = corr_ff;
   assign rsp.payload.silent_block = silent_ff;
   assign rsp.payload.overflow_seen = ovf_ff;

   `FSC_ASSERT_IMPL(a_no_accept_busy, clock, reset, (req.valid && req.ready) |-> state_ff == S_IDLE, "accept outside idle")
   `FSC_ASSERT_IMPL(a_rsp_after_last, clock, reset, $rose(rsp_valid_ff) |-> state_ff == S_OUT, "result without block end")
   `FSC_ASSERT_IMPL(a_silent_zero, clock, reset, (rsp.valid && rsp.payload.silent_block) |-> rsp.payload.correlation == '0, "silent block not zero")
endmodule

// File: rtl/fsc_serial_mac.sv
// Bit-serial multiplier: a * b, signed operands of WIDTH bits; one bit of b a cycle.
module fsc_serial_mac #(
   parameter int WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [WIDTH-1:0] a,
   input  logic signed [WIDTH-1:0] b,
   output logic                   done,
   output logic signed [2*WIDTH-1:0] product
);
   localparam int CntBits = $clog2(WIDTH + 1);
   logic signed [2*WIDTH-1:0] acc_ff, acc_in, mcand_ff, mcand_in;
   logic [WIDTH-1:0] mplier_ff, mplier_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;

   // shift-add, last bit of b carries negative weight
   always_comb begin
      acc_in = acc_ff; mcand_in = mcand_ff; mplier_in = mplier_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         mcand_in = (2*WIDTH)'(a);
         mplier_in = b;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            if (cnt_ff == CntBits'(WIDTH - 1)) acc_in = acc_ff - mcand_ff;
            else acc_in = acc_ff + mcand_ff;
         end
         mcand_in = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntBits'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in; mcand_ff <= mcand_in; mplier_ff <= mplier_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end
   assign done = done_ff;
   assign product = acc_ff;
endmodule

// File: verif/tb_filtered_stereo_correlation.sv
module tb_filtered_stereo_correlation;
   import fsc_pkg::*;

   // One stereo pair in, one block result out
   typedef struct packed {
      logic signed [15:0] left_sample;
      logic signed [15:0] right_sample;
      logic               last_sample;
   } pair_word_t;

   typedef struct packed {
      logic signed [CorrBits-1:0] correlation;
      logic                       silent_block;
      logic                       overflow_seen;
   } corr_word_t;

   typedef struct {
      logic signed [15:0] l;
      logic signed [15:0] r;
      bit                 last;
      bit                 typed;
      corr_word_t         want;
   } pair_row_t;

   localparam int PairGapMax = 15;
   localparam int DrainCycles = 400;
   localparam int IdleLimit = 20000;
   localparam longint FiltHi = (64'sd1 <<< 23) - 1;
   localparam longint FiltLo = -(64'sd1 <<< 23);
   localparam longint AccMax = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam longint AccMin = 64'h8000_0000_0000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fsc_if #(.payload_type(pair_word_t)) req ();
   fsc_if #(.payload_type(corr_word_t)) rsp ();
   fsc_if #(.payload_type(logic [CoefBits-1:0])) csr ();

   filtered_stereo_correlation i_dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr(csr.sink)
   );

   always #2 clock = ~clock;

   // Predictor state
   longint unsigned coef;
   longint filt_l, filt_r, sum_lr, sum_ll, sum_rr;
   bit sat_seen;
   corr_word_t pending_results[$];
   int errors = 0;
   int idle_cycles = 0;
   int burst_left = 0;

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic longint lowpass(longint y, logic signed [15:0] x);
      longint xs, acc, res;
      xs = longint'(x) <<< 8;
      acc = (65536 - longint'(coef)) * xs + longint'(coef) * y + 32768;
      res = acc >>> 16;
      if (res > FiltHi) res = FiltHi;
      if (res < FiltLo) res = FiltLo;
      return res;
   endfunction

   function automatic longint sat_sum(longint acc, longint p);
      if (p > 0 && acc > AccMax - p) begin
         sat_seen = 1'b1;
         return AccMax;
      end
      if (p < 0 && acc < AccMin - p) begin
         sat_seen = 1'b1;
         return AccMin;
      end
      return acc + p;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, one;
      res = 0;
      one = 64'd1 << 62;
      while (one > v) one = one >> 2;
      while (one != 0) begin
         if (v >= res + one) begin
            v = v - (res + one);
            res = (res >> 1) + one;
         end else begin
            res = res >> 1;
         end
         one = one >> 2;
      end
      return res;
   endfunction

   // Root of energy as s * 2^h, s in [2^30, 2^31)
   function automatic longint unsigned energy_root(longint unsigned e, output int h);
      int sh;
      sh = 0;
      while (e < (64'd1 << 60)) begin
         e = e << 2;
         sh -= 2;
      end
      while (e >= (64'd1 << 62)) begin
         e = e >> 2;
         sh += 2;
      end
      h = sh / 2;
      return int_sqrt(e);
   endfunction

   function automatic longint block_correlation();
      int hl, hr, t;
      longint unsigned d, mag, q, rem;
      bit neg;
      neg = sum_lr < 0;
      d = energy_root(sum_ll, hl) * energy_root(sum_rr, hr);
      mag = neg ? 64'd0 - sum_lr : sum_lr;
      t = 15 - (hl + hr);
      q = mag / d;
      rem = mag % d;
      for (int i = 0; i < t && q <= 32767; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= d) begin
            rem = rem - d;
            q = q | 1;
         end
      end
      if (q > 32767) q = 32767;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic void clear_block();
      filt_l = 0;
      filt_r = 0;
      sum_lr = 0;
      sum_ll = 0;
      sum_rr = 0;
      sat_seen = 1'b0;
   endfunction

   // Advance the predictor by one accepted pair; returns 1 when a result is due
   function automatic bit predict_pair(pair_word_t w, output corr_word_t res);
      bit silent;
      longint corr;
      filt_l = lowpass(filt_l, w.left_sample);
      filt_r = lowpass(filt_r, w.right_sample);
      sum_lr = sat_sum(sum_lr, filt_l * filt_r);
      sum_ll = sat_sum(sum_ll, filt_l * filt_l);
      sum_rr = sat_sum(sum_rr, filt_r * filt_r);
      res = '0;
      if (!w.last_sample) return 1'b0;
      silent = (sum_ll == 0 || sum_rr == 0);
      corr = silent ? 0 : block_correlation();
      res.correlation = corr[15:0];
      res.silent_block = silent;
      res.overflow_seen = sat_seen;
      clear_block();
      return 1'b1;
   endfunction

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result word", rsp.payload.correlation, 0);
         end else begin
            corr_word_t w;
            w = pending_results.pop_front();
            if (rsp.payload.correlation !== w.correlation)
               report_mismatch("correlation", rsp.payload.correlation, w.correlation);
            if (rsp.payload.silent_block !== w.silent_block)
               report_mismatch("silent_block", rsp.payload.silent_block, w.silent_block);
            if (rsp.payload.overflow_seen !== w.overflow_seen)
               report_mismatch("overflow_seen", rsp.payload.overflow_seen, w.overflow_seen);
         end
      end
   end

   // Receiver stall pattern: alternating stretches of full rate and random stalls
   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= (stall_phase + 1) % 700;
      if (stall_phase < 250) rsp.ready <= 1'b1;
      else if (stall_phase < 500) rsp.ready <= ($urandom_range(0, 3) != 0);
      else rsp.ready <= ($urandom_range(0, 4) == 0);
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Send one pair; the word is predicted when accepted
   task automatic send_pair(logic signed [15:0] l, logic signed [15:0] r, bit last,
                            bit typed, corr_word_t want);
      pair_word_t w;
      corr_word_t res;
      int gap;
      w.left_sample = l;
      w.right_sample = r;
      w.last_sample = last;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, PairGapMax);
         if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req.valid <= 1'b1;
      req.payload <= w;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      burst_left--;
      if (predict_pair(w, res)) pending_results.push_back(typed ? want : res);
   endtask

   task automatic write_coef(logic [CoefBits-1:0] v);
      csr.valid <= 1'b1;
      csr.payload <= v;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      coef = v;
   endtask

   task automatic wait_idle();
      req.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return $urandom_range(0, 255) - 128;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   // Directed rows: typed results only where obvious
   function automatic pair_row_t row(int l, int r, bit last, bit typed = 0,
                                     int corr = 0, bit silent = 0);
      pair_row_t x;
      x.l = l;
      x.r = r;
      x.last = last;
      x.typed = typed;
      x.want.correlation = corr;
      x.want.silent_block = silent;
      x.want.overflow_seen = 1'b0;
      return x;
   endfunction

   pair_row_t directed[$];
   corr_word_t no_want;
   logic [CoefBits-1:0] coef_plan[$];

   initial begin
      int blk_len, rel;
      logic signed [15:0] l, r;
      req.valid = 1'b0;
      req.payload = '0;
      csr.valid = 1'b0;
      csr.payload = '0;
      rsp.ready = 1'b0;
      no_want = '0;
      coef = CoefReset;
      clear_block();

      // Silent block, equal, opposite, one silent channel, extremes, single-pair block
      directed.push_back(row(0, 0, 1, 1, 0, 1));
      directed.push_back(row(1000, 1000, 0));
      directed.push_back(row(-5000, -5000, 1, 1, 32767, 0));
      directed.push_back(row(20000, -20000, 0));
      directed.push_back(row(-7, 7, 1, 1, -32767, 0));
      directed.push_back(row(12345, 0, 0));
      directed.push_back(row(-300, 0, 1, 1, 0, 1));
      directed.push_back(row(0, 32767, 1, 1, 0, 1));
      directed.push_back(row(32767, 32767, 0));
      directed.push_back(row(-32768, -32768, 0));
      directed.push_back(row(32767, -32768, 0));
      directed.push_back(row(-32768, 32767, 1));
      directed.push_back(row(1, -1, 0));
      directed.push_back(row(-1, 1, 1));
      directed.push_back(row(32767, 100, 0));
      directed.push_back(row(-200, 32767, 0));
      directed.push_back(row(5, -32768, 1));
      directed.push_back(row(32767, 32767, 1, 1, 32767, 0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_pair(directed[i].l, directed[i].r, directed[i].last,
                   directed[i].typed, directed[i].want);

      // Random phases over a spread of coefficients, extremes included
      coef_plan = '{16'd0, 16'hFFFF, 16'd1, 16'h8000, CoefReset,
                    16'($urandom), 16'hFFFE, 16'($urandom)};
      foreach (coef_plan[p]) begin
         wait_idle();
         write_coef(coef_plan[p]);
         @(posedge clock);
         for (int n = 0; n < 170;) begin
            blk_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
            rel = $urandom_range(0, 4);
            for (int k = 0; k < blk_len; k++) begin
               l = pick_sample();
               case (rel)
                  0: r = l;
                  1: r = -l;
                  2: r = l + $urandom_range(0, 511) - 256;
                  3: r = ($urandom_range(0, 7) == 0) ? 16'sd0 : pick_sample();
                  default: r = pick_sample();
               endcase
               send_pair(l, r, k == blk_len - 1, 1'b0, no_want);
               n++;
            end
         end
      end

      wait_idle();
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
